[rtl/core/range_max_segment_tree_top_defines.svh]
// Assertion macros for the range maximum segment tree
`ifndef RANGE_MAX_SEGMENT_TREE_TOP_DEFINES_SVH
`define RANGE_MAX_SEGMENT_TREE_TOP_DEFINES_SVH

// Plain concurrent check, disabled while in reset
`define RMST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Cause in one cycle, effect in the next
`define RMST_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/rmst_pkg.sv]
// Shared constants and types of the range maximum segment tree
package rmst_pkg;

  localparam int unsigned LEAVES  = 262144;
  localparam int unsigned NODES   = 2 * LEAVES;
  localparam int unsigned NODE_AW = $clog2(NODES);
  localparam int unsigned QW      = NODE_AW + 1;
  localparam int unsigned POS_W   = 19;
  localparam int unsigned VAL_W   = 31;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    logic [VAL_W-1:0]   wdata;
    logic               re;
    logic [NODE_AW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_QL   = 4'b0100,
    S_QR   = 4'b1000
  } state_e;

endpackage

[rtl/core/rmst_node_store.sv]
// Node maximum memory with the clearing sweep after reset
module rmst_node_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmst_pkg::mem_req_t            req_i,
  output logic [rmst_pkg::VAL_W-1:0]    rdata_o,
  output logic                          clearing_o
);

  localparam logic [rmst_pkg::NODE_AW-1:0] LAST_NODE =
    rmst_pkg::NODE_AW'(rmst_pkg::NODES - 1);

  logic [rmst_pkg::VAL_W-1:0]   mem [rmst_pkg::NODES];
  logic [rmst_pkg::VAL_W-1:0]   rdata_q;
  logic                         clearing_q, clearing_d;
  logic [rmst_pkg::NODE_AW-1:0] clr_q, clr_d;
  logic                         we;
  logic [rmst_pkg::NODE_AW-1:0] waddr;
  logic [rmst_pkg::VAL_W-1:0]   wdata;

  // sweep one entry per cycle until the last node is zeroed
  always_comb begin
    clr_d      = clr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_d = clr_q + rmst_pkg::NODE_AW'(1);
      if (clr_q == LAST_NODE) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_comb begin
    we    = clearing_q | req_i.we;
    waddr = clearing_q ? clr_q : req_i.waddr;
    wdata = clearing_q ? '0 : req_i.wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clearing_q;

endmodule

[rtl/core/range_max_segment_tree_top.sv]
// Range maximum segment tree: point update and range maximum query over one node memory
// A request with a bad position gives its registered result in the cycle after acceptance.
// An update is busy while it climbs the tree from the leaf to the root, one tree level per
// cycle, set by the single memory read port. A query visits S_QL and then S_QR for each tree
// level, and its result is registered when it finishes; at most one read per cycle.
// Reset: n_used returns to 1 and the memory is swept to zero, with busy high during the sweep.
module range_max_segment_tree_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [rmst_pkg::POS_W-1:0]  cfg_wdata_i,
  // request
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        command_i,
  input  logic [rmst_pkg::POS_W-1:0]  left_pos_i,
  input  logic [rmst_pkg::POS_W-1:0]  right_pos_i,
  input  logic [rmst_pkg::VAL_W-1:0]  new_value_i,
  // result, one-cycle strobe
  output logic                        done_o,
  output logic [rmst_pkg::VAL_W-1:0]  max_value_o,
  output logic                        bad_range_o
);

  localparam int unsigned NAW = rmst_pkg::NODE_AW;
  localparam int unsigned QW  = rmst_pkg::QW;
  localparam int unsigned VW  = rmst_pkg::VAL_W;
  localparam int unsigned PW  = rmst_pkg::POS_W;

  rmst_pkg::state_e   state_q, state_d;
  rmst_pkg::mem_req_t mem_req;

  logic [PW-1:0]  n_used_q, n_used_d;
  logic [NAW-1:0] idx_q, idx_d;      // current node on the update path
  logic [VW-1:0]  carry_q, carry_d;  // value just written on the update path
  logic [QW-1:0]  l_q, l_d, r_q, r_d;
  logic [QW-1:0]  r_dec;
  logic [VW-1:0]  res_q, res_d;      // running query maximum
  logic           pend_q, pend_d;    // a read issued last cycle feeds the maximum
  logic           done_q, done_d;
  logic [VW-1:0]  maxv_q, maxv_d;
  logic           bad_q, bad_d;

  logic [VW-1:0]  rdata;
  logic           clearing;
  logic [PW-1:0]  limit;
  logic           lp_ok, rp_ok;
  logic           accept;
  logic [NAW-1:0] leaf;
  logic [NAW-1:0] nxt_idx;
  logic [VW-1:0]  upd_max;
  logic [VW-1:0]  acc;

  rmst_node_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rdata_o    (rdata),
    .clearing_o (clearing)
  );

  // legal positions are 1 .. min(n_used, LEAVES)
  assign limit = (32'(n_used_q) < rmst_pkg::LEAVES) ? n_used_q : PW'(rmst_pkg::LEAVES);
  assign lp_ok = (left_pos_i != '0) && (left_pos_i <= limit);
  assign rp_ok = (right_pos_i != '0) && (right_pos_i <= limit);

  assign busy_o = (state_q != rmst_pkg::S_IDLE) || clearing;
  assign accept = start_i && !busy_o;

  assign leaf    = NAW'(rmst_pkg::LEAVES) + NAW'(left_pos_i) - NAW'(1);
  assign nxt_idx = idx_q >> 1;
  assign upd_max = (rdata > carry_q) ? rdata : carry_q;
  assign acc     = (pend_q && (rdata > res_q)) ? rdata : res_q;

  always_comb begin
    state_d  = state_q;
    n_used_d = n_used_q;
    idx_d    = idx_q;
    carry_d  = carry_q;
    l_d      = l_q;
    r_d      = r_q;
    r_dec    = r_q;
    res_d    = res_q;
    pend_d   = pend_q;
    done_d   = 1'b0;
    maxv_d   = maxv_q;
    bad_d    = bad_q;
    mem_req  = '0;

    if (cfg_we_i) begin
      n_used_d = cfg_wdata_i;
    end

    case (state_q)
      rmst_pkg::S_IDLE: begin
        if (accept) begin
          if (command_i == rmst_pkg::CMD_UPDATE) begin
            if (lp_ok) begin
              // write the leaf and fetch its sibling in the same cycle
              mem_req.we    = 1'b1;
              mem_req.waddr = leaf;
              mem_req.wdata = new_value_i;
              mem_req.re    = 1'b1;
              mem_req.raddr = leaf ^ NAW'(1);
              idx_d         = leaf;
              carry_d       = new_value_i;
              state_d       = rmst_pkg::S_UPD;
            end else begin
              done_d = 1'b1;
              maxv_d = '0;
              bad_d  = 1'b1;
            end
          end else begin
            if (lp_ok && rp_ok) begin
              l_d     = QW'(rmst_pkg::LEAVES) + QW'(left_pos_i) - QW'(1);
              r_d     = QW'(rmst_pkg::LEAVES) + QW'(right_pos_i);
              res_d   = '0;
              pend_d  = 1'b0;
              state_d = rmst_pkg::S_QL;
            end else begin
              done_d = 1'b1;
              maxv_d = '0;
              bad_d  = 1'b1;
            end
          end
        end
      end

      rmst_pkg::S_UPD: begin
        // parent takes the max of the carried child and its sibling
        mem_req.we    = 1'b1;
        mem_req.waddr = nxt_idx;
        mem_req.wdata = upd_max;
        idx_d         = nxt_idx;
        carry_d       = upd_max;
        if (nxt_idx == NAW'(1)) begin
          state_d = rmst_pkg::S_IDLE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = nxt_idx ^ NAW'(1);
        end
      end

      rmst_pkg::S_QL: begin
        res_d  = acc;
        pend_d = 1'b0;
        if (l_q < r_q) begin
          if (l_q[0]) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = l_q[NAW-1:0];
            pend_d        = 1'b1;
            l_d           = l_q + QW'(1);
          end
          state_d = rmst_pkg::S_QR;
        end else begin
          done_d  = 1'b1;
          maxv_d  = acc;
          bad_d   = 1'b0;
          state_d = rmst_pkg::S_IDLE;
        end
      end

      rmst_pkg::S_QR: begin
        res_d  = acc;
        pend_d = 1'b0;
        if (r_q[0]) begin
          r_dec         = r_q - QW'(1);
          mem_req.re    = 1'b1;
          mem_req.raddr = r_dec[NAW-1:0];
          pend_d        = 1'b1;
        end
        // climb one level
        l_d     = l_q >> 1;
        r_d     = r_dec >> 1;
        state_d = rmst_pkg::S_QL;
      end

      default: begin
        state_d = rmst_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rmst_pkg::S_IDLE;
      n_used_q <= PW'(1);
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_used_q <= n_used_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    carry_q <= carry_d;
    l_q     <= l_d;
    r_q     <= r_d;
    res_q   <= res_d;
    maxv_q  <= maxv_d;
    bad_q   <= bad_d;
  end

  assign done_o      = done_q;
  assign max_value_o = maxv_q;
  assign bad_range_o = bad_q;

endmodule

[rtl/core/rmst_checker.sv]
// Port-level checks of the range maximum segment tree, bound to the top level
`include "range_max_segment_tree_top_defines.svh"

module rmst_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic [rmst_pkg::POS_W-1:0]  left_pos_i,
  input logic                        done_o,
  input logic [rmst_pkg::VAL_W-1:0]  max_value_o,
  input logic                        bad_range_o
);

  logic accept;
  logic quiet;
  logic lp_zero;
  logic bad_done;

  assign accept   = start_i && !busy_o;
  assign quiet    = !busy_o && !start_i;
  assign lp_zero  = (left_pos_i == '0);
  assign bad_done = done_o && bad_range_o;

  `RMST_ASSERT_NEXT(a_accept_acts, clk_i, rst_ni, accept, busy_o || done_o, "request dropped")

  `RMST_ASSERT_NEXT(a_no_stray_done, clk_i, rst_ni, quiet, !done_o, "result without a request")

  `RMST_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy_o, "result strobe while busy")

  `RMST_ASSERT(a_bad_zero, clk_i, rst_ni, bad_done |-> (max_value_o == '0), "error result not zero")

  `RMST_ASSERT_NEXT(a_pos_zero_bad, clk_i, rst_ni, accept && lp_zero, bad_done, "position zero passed")

endmodule

bind range_max_segment_tree_top rmst_checker u_rmst_checker (.*);
